### rtl/tls_sni_pkg.sv
// ----------------------------------------------------------------------------
// tls_sni_pkg
// Shared types and constants for the TLS server-name extractor.
// ----------------------------------------------------------------------------
package tls_sni_pkg;

    localparam logic [7:0]  CONTENT_HANDSHAKE = 8'd22;
    localparam int          RANDOM_LEN        = 32;
    localparam logic [15:0] FIXED_SKIP        = 16'(1 + 3 + 2 + RANDOM_LEN);
    localparam logic [16:0] EXT_HEADER_LEN    = 17'd4;

    localparam logic [9:0]  MAX_HOST_RESET    = 10'd255;
    localparam logic [14:0] MAX_RECORD_RESET  = 15'd1500;

    // configuration register indexes
    localparam logic REG_MAX_HOST_LEN   = 1'b0;
    localparam logic REG_MAX_RECORD_LEN = 1'b1;
    localparam int   CFG_DW             = 15;

    // result queue
    localparam int RES_DEPTH = 4;
    localparam int RES_AW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    localparam logic KIND_HOST   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_PARTIAL = 3'd0,
        ST_OK      = 3'd1,
        ST_INVALID = 3'd2,
        ST_OVERRUN = 3'd3,
        ST_NOHOST  = 3'd4,
        ST_TOOLONG = 3'd5
    } t_status;

    typedef enum logic [4:0] {
        PH_TYPE, PH_VER0, PH_VER1, PH_LEN_HI, PH_LEN_LO,
        PH_FIXED, PH_SID_LEN, PH_SID, PH_CS_HI, PH_CS_LO, PH_CS,
        PH_COMP_LEN, PH_COMP, PH_EXTS_HI, PH_EXTS_LO,
        PH_EXT_TYPE_HI, PH_EXT_TYPE_LO, PH_EXT_LEN_HI, PH_EXT_LEN_LO, PH_EXT_SKIP,
        PH_LIST_HI, PH_LIST_LO, PH_NAME_TYPE, PH_NAME_LEN_HI, PH_NAME_LEN_LO,
        PH_NAME_SKIP, PH_HOST
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] name_byte;
        t_status    status;
        logic       last;
    } t_result;

    // up to two results per item, the second only behind the first
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result d0;
        t_result d1;
    } t_push;

endpackage

### rtl/tls_sni_parse.sv
// ----------------------------------------------------------------------------
// tls_sni_parse
// Record parser state and the per-byte decision logic; one item per fire.
// ----------------------------------------------------------------------------
module tls_sni_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  tls_sni_pkg::t_in_item i_item,
    input  logic [9:0]           i_max_host_len,
    input  logic [14:0]          i_max_record_len,
    output tls_sni_pkg::t_push   o_push
);

    tls_sni_pkg::t_phase r_phase, n_phase;
    logic [14:0] r_record_count, n_record_count;
    logic [15:0] r_record_length, n_record_length;
    logic [15:0] r_field_count, n_field_count;
    logic        r_ext_is_sni, n_ext_is_sni;
    logic [15:0] r_ext_remaining, n_ext_remaining;
    logic [15:0] r_list_remaining, n_list_remaining;
    logic        r_name_is_host, n_name_is_host;
    logic [15:0] r_name_remaining, n_name_remaining;
    logic        r_decided, n_decided;

    logic [7:0]  w_b;
    logic [14:0] w_rc_inc;
    logic        w_ext_end;
    logic [15:0] w_fc_lo;
    logic [15:0] w_er_lo;
    logic [15:0] w_lr_dec;
    logic        w_host_emit;
    logic        w_st_emit;
    tls_sni_pkg::t_status w_st_code;
    tls_sni_pkg::t_result w_host_res;
    tls_sni_pkg::t_result w_st_res;

    assign w_b      = i_item.byte_in;
    assign w_rc_inc = r_record_count + 15'd1;
    // too few body bytes left for another extension header
    assign w_ext_end = ({1'b0, r_record_length} <=
                        ({2'b00, w_rc_inc} + tls_sni_pkg::EXT_HEADER_LEN));
    assign w_fc_lo  = {r_field_count[15:8], w_b};
    assign w_er_lo  = {r_ext_remaining[15:8], w_b};
    assign w_lr_dec = r_list_remaining - 16'd1;

    always_comb begin
        n_phase          = r_phase;
        n_record_count   = r_record_count;
        n_record_length  = r_record_length;
        n_field_count    = r_field_count;
        n_ext_is_sni     = r_ext_is_sni;
        n_ext_remaining  = r_ext_remaining;
        n_list_remaining = r_list_remaining;
        n_name_is_host   = r_name_is_host;
        n_name_remaining = r_name_remaining;
        n_decided        = r_decided;
        w_host_emit      = 1'b0;
        w_st_emit        = 1'b0;
        w_st_code        = tls_sni_pkg::ST_PARTIAL;

        if (!r_decided) begin
            case (r_phase)
                tls_sni_pkg::PH_TYPE: begin
                    if (w_b != tls_sni_pkg::CONTENT_HANDSHAKE) begin
                        n_decided = 1'b1;
                        w_st_emit = 1'b1;
                        w_st_code = tls_sni_pkg::ST_INVALID;
                    end else begin
                        n_phase = tls_sni_pkg::PH_VER0;
                    end
                end
                tls_sni_pkg::PH_VER0: n_phase = tls_sni_pkg::PH_VER1;
                tls_sni_pkg::PH_VER1: n_phase = tls_sni_pkg::PH_LEN_HI;
                tls_sni_pkg::PH_LEN_HI: begin
                    n_record_length = {w_b, 8'h00};
                    n_phase         = tls_sni_pkg::PH_LEN_LO;
                end
                tls_sni_pkg::PH_LEN_LO: begin
                    n_record_length = {r_record_length[15:8], w_b};
                    if (n_record_length > {1'b0, i_max_record_len}) begin
                        n_decided = 1'b1;
                        w_st_emit = 1'b1;
                        w_st_code = tls_sni_pkg::ST_OVERRUN;
                    end else begin
                        n_record_count = '0;
                        n_field_count  = tls_sni_pkg::FIXED_SKIP;
                        n_phase        = tls_sni_pkg::PH_FIXED;
                        if (n_record_length == 16'd0) begin
                            n_decided = 1'b1;
                            w_st_emit = 1'b1;
                            w_st_code = tls_sni_pkg::ST_NOHOST;
                        end
                    end
                end
                default: begin
                    n_record_count = w_rc_inc;
                    case (r_phase)
                        tls_sni_pkg::PH_FIXED: begin
                            n_field_count = r_field_count - 16'd1;
                            if (n_field_count == 16'd0) n_phase = tls_sni_pkg::PH_SID_LEN;
                        end
                        tls_sni_pkg::PH_SID_LEN: begin
                            n_field_count = {8'h00, w_b};
                            n_phase = (w_b == 8'd0) ? tls_sni_pkg::PH_CS_HI
                                                    : tls_sni_pkg::PH_SID;
                        end
                        tls_sni_pkg::PH_SID: begin
                            n_field_count = r_field_count - 16'd1;
                            if (n_field_count == 16'd0) n_phase = tls_sni_pkg::PH_CS_HI;
                        end
                        tls_sni_pkg::PH_CS_HI: begin
                            n_field_count = {w_b, 8'h00};
                            n_phase       = tls_sni_pkg::PH_CS_LO;
                        end
                        tls_sni_pkg::PH_CS_LO: begin
                            n_field_count = w_fc_lo;
                            n_phase = (w_fc_lo == 16'd0) ? tls_sni_pkg::PH_COMP_LEN
                                                         : tls_sni_pkg::PH_CS;
                        end
                        tls_sni_pkg::PH_CS: begin
                            n_field_count = r_field_count - 16'd1;
                            if (n_field_count == 16'd0) n_phase = tls_sni_pkg::PH_COMP_LEN;
                        end
                        tls_sni_pkg::PH_COMP_LEN: begin
                            n_field_count = {8'h00, w_b};
                            n_phase = (w_b == 8'd0) ? tls_sni_pkg::PH_EXTS_HI
                                                    : tls_sni_pkg::PH_COMP;
                        end
                        tls_sni_pkg::PH_COMP: begin
                            n_field_count = r_field_count - 16'd1;
                            if (n_field_count == 16'd0) n_phase = tls_sni_pkg::PH_EXTS_HI;
                        end
                        tls_sni_pkg::PH_EXTS_HI: n_phase = tls_sni_pkg::PH_EXTS_LO;
                        tls_sni_pkg::PH_EXTS_LO: begin
                            if (w_ext_end) begin
                                n_decided = 1'b1;
                                w_st_emit = 1'b1;
                                w_st_code = tls_sni_pkg::ST_NOHOST;
                            end else begin
                                n_phase = tls_sni_pkg::PH_EXT_TYPE_HI;
                            end
                        end
                        tls_sni_pkg::PH_EXT_TYPE_HI: begin
                            n_ext_is_sni = (w_b == 8'd0);
                            n_phase      = tls_sni_pkg::PH_EXT_TYPE_LO;
                        end
                        tls_sni_pkg::PH_EXT_TYPE_LO: begin
                            n_ext_is_sni = r_ext_is_sni & (w_b == 8'd0);
                            n_phase      = tls_sni_pkg::PH_EXT_LEN_HI;
                        end
                        tls_sni_pkg::PH_EXT_LEN_HI: begin
                            n_ext_remaining = {w_b, 8'h00};
                            n_phase         = tls_sni_pkg::PH_EXT_LEN_LO;
                        end
                        tls_sni_pkg::PH_EXT_LEN_LO: begin
                            n_ext_remaining = w_er_lo;
                            if (r_ext_is_sni) begin
                                n_phase = tls_sni_pkg::PH_LIST_HI;
                            end else if (w_er_lo != 16'd0) begin
                                n_phase = tls_sni_pkg::PH_EXT_SKIP;
                            end else if (w_ext_end) begin
                                n_decided = 1'b1;
                                w_st_emit = 1'b1;
                                w_st_code = tls_sni_pkg::ST_NOHOST;
                            end else begin
                                n_phase = tls_sni_pkg::PH_EXT_TYPE_HI;
                            end
                        end
                        tls_sni_pkg::PH_EXT_SKIP: begin
                            n_ext_remaining = r_ext_remaining - 16'd1;
                            if (n_ext_remaining == 16'd0) begin
                                if (w_ext_end) begin
                                    n_decided = 1'b1;
                                    w_st_emit = 1'b1;
                                    w_st_code = tls_sni_pkg::ST_NOHOST;
                                end else begin
                                    n_phase = tls_sni_pkg::PH_EXT_TYPE_HI;
                                end
                            end
                        end
                        tls_sni_pkg::PH_LIST_HI: begin
                            n_field_count = {w_b, 8'h00};
                            n_phase       = tls_sni_pkg::PH_LIST_LO;
                        end
                        tls_sni_pkg::PH_LIST_LO: begin
                            n_field_count = w_fc_lo;
                            // list plus its own length field must fit the extension
                            if (({1'b0, w_fc_lo} + 17'd2) > {1'b0, r_ext_remaining}) begin
                                n_decided = 1'b1;
                                w_st_emit = 1'b1;
                                w_st_code = tls_sni_pkg::ST_NOHOST;
                            end else begin
                                n_list_remaining = w_fc_lo;
                                if (w_fc_lo > 16'd3) begin
                                    n_phase = tls_sni_pkg::PH_NAME_TYPE;
                                end else begin
                                    n_decided = 1'b1;
                                    w_st_emit = 1'b1;
                                    w_st_code = tls_sni_pkg::ST_NOHOST;
                                end
                            end
                        end
                        tls_sni_pkg::PH_NAME_TYPE: begin
                            n_name_is_host   = (w_b == 8'd0);
                            n_list_remaining = w_lr_dec;
                            n_phase          = tls_sni_pkg::PH_NAME_LEN_HI;
                        end
                        tls_sni_pkg::PH_NAME_LEN_HI: begin
                            n_field_count    = {w_b, 8'h00};
                            n_list_remaining = w_lr_dec;
                            n_phase          = tls_sni_pkg::PH_NAME_LEN_LO;
                        end
                        tls_sni_pkg::PH_NAME_LEN_LO: begin
                            n_field_count    = w_fc_lo;
                            n_list_remaining = w_lr_dec;
                            if (w_fc_lo > w_lr_dec) begin
                                n_decided = 1'b1;
                                w_st_emit = 1'b1;
                                w_st_code = tls_sni_pkg::ST_NOHOST;
                            end else begin
                                n_list_remaining = w_lr_dec - w_fc_lo;
                                n_name_remaining = w_fc_lo;
                                if (r_name_is_host) begin
                                    if (w_fc_lo > {6'd0, i_max_host_len}) begin
                                        n_decided = 1'b1;
                                        w_st_emit = 1'b1;
                                        w_st_code = tls_sni_pkg::ST_TOOLONG;
                                    end else if (w_fc_lo == 16'd0) begin
                                        n_decided = 1'b1;
                                        w_st_emit = 1'b1;
                                        w_st_code = tls_sni_pkg::ST_OK;
                                    end else begin
                                        n_phase = tls_sni_pkg::PH_HOST;
                                    end
                                end else if (w_fc_lo != 16'd0) begin
                                    n_phase = tls_sni_pkg::PH_NAME_SKIP;
                                end else if (n_list_remaining > 16'd3) begin
                                    n_phase = tls_sni_pkg::PH_NAME_TYPE;
                                end else begin
                                    n_decided = 1'b1;
                                    w_st_emit = 1'b1;
                                    w_st_code = tls_sni_pkg::ST_NOHOST;
                                end
                            end
                        end
                        tls_sni_pkg::PH_NAME_SKIP: begin
                            n_name_remaining = r_name_remaining - 16'd1;
                            if (n_name_remaining == 16'd0) begin
                                if (r_list_remaining > 16'd3) begin
                                    n_phase = tls_sni_pkg::PH_NAME_TYPE;
                                end else begin
                                    n_decided = 1'b1;
                                    w_st_emit = 1'b1;
                                    w_st_code = tls_sni_pkg::ST_NOHOST;
                                end
                            end
                        end
                        tls_sni_pkg::PH_HOST: begin
                            w_host_emit      = 1'b1;
                            n_name_remaining = r_name_remaining - 16'd1;
                            if (n_name_remaining == 16'd0) begin
                                n_decided = 1'b1;
                                w_st_emit = 1'b1;
                                w_st_code = tls_sni_pkg::ST_OK;
                            end
                        end
                        default: begin
                            n_decided = 1'b1;
                            w_st_emit = 1'b1;
                            w_st_code = tls_sni_pkg::ST_NOHOST;
                        end
                    endcase
                    // record body used up without a decision
                    if (!n_decided && ({1'b0, w_rc_inc} >= r_record_length)) begin
                        n_decided = 1'b1;
                        w_st_emit = 1'b1;
                        w_st_code = tls_sni_pkg::ST_NOHOST;
                    end
                end
            endcase
        end

        if (i_item.end_of_buffer) begin
            if (!n_decided) begin
                w_st_emit = 1'b1;
                if ((n_phase <= tls_sni_pkg::PH_LEN_LO) ||
                    ({1'b0, n_record_count} < n_record_length)) begin
                    w_st_code = tls_sni_pkg::ST_PARTIAL;
                end else begin
                    w_st_code = tls_sni_pkg::ST_NOHOST;
                end
            end
            n_phase          = tls_sni_pkg::PH_TYPE;
            n_record_count   = '0;
            n_record_length  = '0;
            n_field_count    = '0;
            n_ext_is_sni     = 1'b0;
            n_ext_remaining  = '0;
            n_list_remaining = '0;
            n_name_is_host   = 1'b0;
            n_name_remaining = '0;
            n_decided        = 1'b0;
        end
    end

    always_comb begin
        w_host_res.kind      = tls_sni_pkg::KIND_HOST;
        w_host_res.name_byte = w_b;
        w_host_res.status    = tls_sni_pkg::ST_PARTIAL;
        w_host_res.last      = 1'b0;
        w_st_res.kind        = tls_sni_pkg::KIND_STATUS;
        w_st_res.name_byte   = 8'h00;
        w_st_res.status      = w_st_code;
        w_st_res.last        = 1'b1;
        o_push.v0 = i_fire & (w_host_emit | w_st_emit);
        o_push.v1 = i_fire & w_host_emit & w_st_emit;
        o_push.d0 = w_host_emit ? w_host_res : w_st_res;
        o_push.d1 = w_st_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= tls_sni_pkg::PH_TYPE;
            r_record_count   <= '0;
            r_record_length  <= '0;
            r_field_count    <= '0;
            r_ext_is_sni     <= 1'b0;
            r_ext_remaining  <= '0;
            r_list_remaining <= '0;
            r_name_is_host   <= 1'b0;
            r_name_remaining <= '0;
            r_decided        <= 1'b0;
        end else if (i_fire) begin
            r_phase          <= n_phase;
            r_record_count   <= n_record_count;
            r_record_length  <= n_record_length;
            r_field_count    <= n_field_count;
            r_ext_is_sni     <= n_ext_is_sni;
            r_ext_remaining  <= n_ext_remaining;
            r_list_remaining <= n_list_remaining;
            r_name_is_host   <= n_name_is_host;
            r_name_remaining <= n_name_remaining;
            r_decided        <= n_decided;
        end
    end

endmodule

### rtl/tls_sni_rqueue.sv
// ----------------------------------------------------------------------------
// tls_sni_rqueue
// Result queue: takes up to two results a cycle, hands out one a cycle while i_stall is low.
// ----------------------------------------------------------------------------
module tls_sni_rqueue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tls_sni_pkg::t_push   i_push,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_stall,
    output tls_sni_pkg::t_result o_result
);

    tls_sni_pkg::t_result r_mem [tls_sni_pkg::RES_DEPTH];
    logic [tls_sni_pkg::RES_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [tls_sni_pkg::RES_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [tls_sni_pkg::RES_CW-1:0] r_count, n_count;
    logic w_pop;

    // room for the worst case of two results from one item
    assign o_room   = (r_count <= tls_sni_pkg::RES_CW'(tls_sni_pkg::RES_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign w_pop    = o_valid & ~i_stall;
    assign o_result = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + tls_sni_pkg::RES_AW'(i_push.v0) + tls_sni_pkg::RES_AW'(i_push.v1);
        n_rd_ptr = r_rd_ptr + tls_sni_pkg::RES_AW'(w_pop);
        n_count  = r_count + tls_sni_pkg::RES_CW'(i_push.v0)
                 + tls_sni_pkg::RES_CW'(i_push.v1) - tls_sni_pkg::RES_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr_ptr] <= i_push.d0;
        end
        if (i_push.v1) begin
            r_mem[r_wr_ptr + tls_sni_pkg::RES_AW'(1)] <= i_push.d1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/tls_sni_host_extractor_unit.sv
// path: an accepted item waits in the input register until the result queue has room, then its results are queued
// throughput: one item per cycle while the four-entry result queue has room for two;
//   results leave one per cycle while i_stall is low; a host byte that also ends the name brings its status behind it
// reset: i_rst_n synchronous, active low; clears the parser, the input register and
//   the result queue, and sets max_host_len to 255 and max_record_len to 1500
// ----------------------------------------------------------------------------
// tls_sni_host_extractor_unit
// Extracts the server-name host bytes and a final status from a TLS record.
// ----------------------------------------------------------------------------
module tls_sni_host_extractor_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  tls_sni_pkg::t_in_item              i_item,
    output logic                               o_valid,
    input  logic                               i_stall,
    output tls_sni_pkg::t_result               o_result,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [tls_sni_pkg::CFG_DW-1:0]     i_cfg_data
);

    logic [9:0]            r_max_host_len;
    logic [14:0]           r_max_record_len;
    logic                  r_in_valid;
    tls_sni_pkg::t_in_item r_in;
    logic                  w_room;
    logic                  w_fire;
    tls_sni_pkg::t_push    w_push;

    assign w_fire  = r_in_valid & w_room;
    assign o_stall = r_in_valid & ~w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_host_len   <= tls_sni_pkg::MAX_HOST_RESET;
            r_max_record_len <= tls_sni_pkg::MAX_RECORD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tls_sni_pkg::REG_MAX_HOST_LEN:   r_max_host_len   <= i_cfg_data[9:0];
                tls_sni_pkg::REG_MAX_RECORD_LEN: r_max_record_len <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_item;
        end
    end

    tls_sni_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_item           (r_in),
        .i_max_host_len   (r_max_host_len),
        .i_max_record_len (r_max_record_len),
        .o_push           (w_push)
    );

    tls_sni_rqueue u_rqueue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_room   (w_room),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // a second result is always a status behind a host byte
    a_two_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.v1 |-> (w_push.v0 && w_push.d0.kind == tls_sni_pkg::KIND_HOST
                       && w_push.d1.kind == tls_sni_pkg::KIND_STATUS))
        else $error("second result is not a status after a host byte");

    // results only come from an item taken out of the input register
    a_push_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.v0 |-> w_fire)
        else $error("result pushed without a fired item");

    // the queue never has to drop a result
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> w_room)
        else $error("item fired without queue room");

    // host bytes never close the record
    a_host_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.kind == tls_sni_pkg::KIND_HOST) |-> !o_result.last)
        else $error("host byte marked last");
`endif

endmodule
